### src/keypad_edge_and_autorepeat_top_defines.svh
// Assertion macros shared by the keypad qualifier RTL.
// Build with ASSERT_OFF defined to drop every check.
`ifndef KEYPAD_EDGE_AND_AUTOREPEAT_TOP_DEFINES_SVH
`define KEYPAD_EDGE_AND_AUTOREPEAT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge of i_clk, masked while in reset.
`define KPAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked on every rising edge, masked while in reset.
`define KPAR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define KPAR_ASSERT(lbl, prop, msg)
`define KPAR_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

### src/kpar_pkg.sv
package kpar_pkg;

    // Field widths
    localparam int KEYS_W      = 56;
    localparam int GRP_W       = 8;
    localparam int KEY_W       = 11;
    localparam int DELAY_W     = 8;
    localparam int RATE_W      = 8;
    localparam int HOLD_W      = 16;
    localparam int PHASE_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // Defaults
    localparam int KEY_GROUPS_DEF = 7;
    localparam logic [DELAY_W-1:0] DELAY_RST = 8'd18;
    localparam logic [RATE_W-1:0]  RATE_RST  = 8'd4;
    localparam logic [KEY_W-1:0]   LOCK_RST  = 11'd288;

    typedef logic [KEYS_W-1:0] t_keys;
    typedef logic [KEY_W-1:0]  t_key;

    typedef enum logic [1:0] {
        FUNC_SCAN   = 2'd0,
        FUNC_RESYNC = 2'd1,
        FUNC_QUERY  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY = 2'd0,
        CFG_RATE  = 2'd1,
        CFG_LOCK  = 2'd2
    } t_cfg_idx;

    // Input beat
    typedef struct packed {
        t_func func;
        t_keys key_groups;
        logic  on_level;
        t_key  query_key;
    } t_in;

    // Result beat
    typedef struct packed {
        t_keys             new_presses;
        logic              on_held;
        logic              on_edge;
        logic              lock_combo;
        logic              all_idle;
        logic              key_down;
        logic              key_pressed;
        logic              repeat_fire;
        logic [HOLD_W-1:0] held_count;
    } t_out;

    // Register file contents handed to the datapath
    typedef struct packed {
        logic [DELAY_W-1:0] typ_delay;
        logic [RATE_W-1:0]  typ_rate;
        t_key               lock_key_code;
    } t_cfg;

endpackage

### src/kpar_core.sv
`include "keypad_edge_and_autorepeat_top_defines.svh"

module kpar_core #(
    parameter int KEY_GROUPS = kpar_pkg::KEY_GROUPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  kpar_pkg::t_in  i_in,
    input  kpar_pkg::t_cfg i_cfg,
    output kpar_pkg::t_out o_res
);
    import kpar_pkg::*;

    localparam int SNAP_W = GRP_W * KEY_GROUPS;

    // Pick the 8-bit group that a key code names; groups out of range read as up.
    function automatic logic [GRP_W-1:0] f_grp(input logic [SNAP_W-1:0] snap,
                                               input t_key key);
        logic [GRP_W-1:0] g;
        g = '0;
        for (int i = 0; i < KEY_GROUPS; i++) begin
            if (key[KEY_W-1:GRP_W] == 3'(i + 1)) begin
                g = snap[GRP_W*i +: GRP_W];
            end
        end
        return g;
    endfunction

    // State
    logic [SNAP_W-1:0]  r_now,     n_now;
    logic [SNAP_W-1:0]  r_last,    n_last;
    logic               r_on_now,  n_on_now;
    logic               r_on_last, n_on_last;
    t_key               r_tracked, n_tracked;
    logic [HOLD_W-1:0]  r_hold,    n_hold;
    logic [PHASE_W-1:0] r_phase,   n_phase;

    // Query terms
    logic               q_down;
    logic               q_was;
    logic               q_fire;
    logic [HOLD_W-1:0]  hold_inc;
    logic [PHASE_W:0]   phase_inc;
    logic               on_edge;

    assign q_down    = (f_grp(r_now,  i_in.query_key) & i_in.query_key[GRP_W-1:0]) != '0;
    assign q_was     = (f_grp(r_last, i_in.query_key) & i_in.query_key[GRP_W-1:0]) != '0;
    assign hold_inc  = (r_hold == '1) ? r_hold : r_hold + 1'b1;
    assign phase_inc = {1'b0, r_phase} + 1'b1;

    // Next state for snapshots and repeat tracker
    always_comb begin
        n_now     = r_now;
        n_last    = r_last;
        n_on_now  = r_on_now;
        n_on_last = r_on_last;
        n_tracked = r_tracked;
        n_hold    = r_hold;
        n_phase   = r_phase;
        q_fire    = 1'b0;
        unique case (i_in.func)
            FUNC_SCAN: begin
                n_last    = r_now;
                n_now     = i_in.key_groups[SNAP_W-1:0];
                n_on_last = r_on_now;
                n_on_now  = i_in.on_level;
            end
            FUNC_RESYNC: begin
                n_now     = i_in.key_groups[SNAP_W-1:0];
                n_last    = i_in.key_groups[SNAP_W-1:0];
                n_on_now  = i_in.on_level;
                n_on_last = i_in.on_level;
                n_tracked = '0;
                n_hold    = '0;
                n_phase   = '0;
            end
            FUNC_QUERY: begin
                priority if (!q_down) begin
                    // key released: drop it if it was being tracked
                    if (r_tracked == i_in.query_key) begin
                        n_tracked = '0;
                        n_hold    = '0;
                        n_phase   = '0;
                    end
                end else if (r_tracked != i_in.query_key) begin
                    // first press fires and starts tracking
                    n_tracked = i_in.query_key;
                    n_hold    = '0;
                    n_phase   = '0;
                    q_fire    = 1'b1;
                end else begin
                    n_hold = hold_inc;
                    priority if (hold_inc < HOLD_W'(i_cfg.typ_delay)) begin
                        q_fire = 1'b0;
                    end else if (hold_inc == HOLD_W'(i_cfg.typ_delay)) begin
                        n_phase = '0;
                        q_fire  = 1'b1;
                    end else if (phase_inc >= (PHASE_W+1)'(i_cfg.typ_rate)) begin
                        n_phase = '0;
                        q_fire  = 1'b1;
                    end else begin
                        n_phase = phase_inc[PHASE_W-1:0];
                    end
                end
            end
            default: begin
                // unused code: state holds
            end
        endcase
    end

    // Result from the snapshots after this beat
    assign on_edge = n_on_now & ~n_on_last;

    always_comb begin
        o_res             = '0;
        o_res.new_presses = t_keys'(n_now & ~n_last);
        o_res.on_held     = n_on_now;
        o_res.on_edge     = on_edge;
        o_res.lock_combo  = on_edge &&
            ((f_grp(n_now, i_cfg.lock_key_code) & i_cfg.lock_key_code[GRP_W-1:0]) != '0);
        o_res.all_idle    = (n_now == '0);
        o_res.held_count  = n_hold;
        if (i_in.func == FUNC_QUERY) begin
            o_res.key_down    = q_down;
            o_res.key_pressed = q_down & ~q_was;
            o_res.repeat_fire = q_fire;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= '0;
            r_last    <= '0;
            r_on_now  <= 1'b0;
            r_on_last <= 1'b0;
            r_tracked <= '0;
            r_hold    <= '0;
            r_phase   <= '0;
        end else if (i_acc) begin
            r_now     <= n_now;
            r_last    <= n_last;
            r_on_now  <= n_on_now;
            r_on_last <= n_on_last;
            r_tracked <= n_tracked;
            r_hold    <= n_hold;
            r_phase   <= n_phase;
        end
    end

    // Checks
    `KPAR_ASSERT_IMP(a_idle_tracker, r_tracked == '0,
        (r_hold == '0) && (r_phase == '0), "tracker count without key")
    `KPAR_ASSERT_IMP(a_fire_needs_down, o_res.repeat_fire, o_res.key_down,
        "repeat fired on a key that is up")
    `KPAR_ASSERT(a_resync_clears, (i_acc && (i_in.func == FUNC_RESYNC)) |=>
        ((r_tracked == '0) && (r_hold == '0)), "resync left tracker set")

endmodule

### src/keypad_edge_and_autorepeat_top.sv
// Keypad qualifier with typematic autorepeat. One input beat (scan, resync or key
// query) is taken per clock while o_stall is low and gives exactly one result beat;
// the snapshot compare and the repeat counter update are a single combinational pass
// from the held state to the output register. An output register plus one skid entry
// keep input flowing while the consumer stalls: o_stall rises only when both are full.
// Registers (delay, rate, lock key) are written on the config channel, always ready;
// the user must write them only while the block is idle; it is not enforced.
`include "keypad_edge_and_autorepeat_top_defines.svh"

module keypad_edge_and_autorepeat_top #(
    parameter int KEY_GROUPS = kpar_pkg::KEY_GROUPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input beats
    input  logic                            i_valid,
    output logic                            o_stall,
    input  kpar_pkg::t_in                   i_data,
    // result beats
    output logic                            o_valid,
    input  logic                            i_stall,
    output kpar_pkg::t_out                  o_data,
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kpar_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kpar_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kpar_pkg::*;

    t_cfg r_cfg;
    t_out res;
    logic acc;

    t_out r_out;
    logic r_out_vld;
    t_out r_skd;
    logic r_skd_vld;
    logic out_free;

    assign o_stall     = r_skd_vld;
    assign acc         = i_valid && !r_skd_vld;
    assign out_free    = !r_out_vld || !i_stall;
    assign o_valid     = r_out_vld;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.typ_delay     <= DELAY_RST;
            r_cfg.typ_rate      <= RATE_RST;
            r_cfg.lock_key_code <= LOCK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DELAY: r_cfg.typ_delay     <= i_cfg_data[DELAY_W-1:0];
                CFG_RATE:  r_cfg.typ_rate      <= i_cfg_data[RATE_W-1:0];
                CFG_LOCK:  r_cfg.lock_key_code <= i_cfg_data[KEY_W-1:0];
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // Snapshot and repeat datapath
    kpar_core #(
        .KEY_GROUPS (KEY_GROUPS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_in    (i_data),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Output register with one skid entry: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skd_vld) begin
                r_out_vld <= 1'b1;
                r_skd_vld <= 1'b0;
            end else begin
                r_out_vld <= acc;
            end
        end else if (acc) begin
            r_skd_vld <= 1'b1;
        end
    end

    // Output register with one skid entry: payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skd_vld) begin
                r_out <= r_skd;
            end else if (acc) begin
                r_out <= res;
            end
        end else if (acc) begin
            r_skd <= res;
        end
    end

    // Checks
    `KPAR_ASSERT_IMP(a_skid_behind_out, r_skd_vld, r_out_vld, "skid entry with empty output register")
    `KPAR_ASSERT(a_accept_shows, acc |=> r_out_vld, "accepted beat produced no result")
    `KPAR_ASSERT(a_skid_kept, (r_skd_vld && i_stall) |=> r_skd_vld, "skid entry lost while stalled")

endmodule
